### src/mnps_pkg.sv
// Package for the mono note priority stack.
// Field widths, action and command codes, controller states, cell control bundle.
// No dependencies.
package mnps_pkg;

    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 7;
    localparam int ACT_W         = 2;
    localparam int STACK_DEPTH_D = 8;
    localparam logic [VEL_W-1:0] ACCENT_RESET = 7'd100;

    typedef enum logic [ACT_W-1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_ALL_OFF  = 2'd2
    } t_action;

    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_GATE_OFF = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              search;
        logic              update;
        logic              shift_all;
        logic [NOTE_W-1:0] key;
    } t_cell_ctl;

endpackage

### src/mnps_if.sv
// Valid/ready channel interfaces for note events and voice commands.
// Depends on mnps_pkg.
interface mnps_in_if import mnps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;

    modport source (output valid, action, note, velocity, input ready);
    modport sink   (input valid, action, note, velocity, output ready);
endinterface

interface mnps_out_if import mnps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [NOTE_W-1:0] pitch_note;
    logic              legato;
    logic              accent;

    modport source (output valid, command, pitch_note, legato, accent, input ready);
    modport sink   (input valid, command, pitch_note, legato, accent, output ready);
endinterface

### src/mono_note_priority_stack.sv
// Mono note priority stack: a row of slot cells run by a four-state controller.
// Each event is accepted, then searched, then shifted/pushed, then emitted to the output register.
// A new event is accepted only in idle, after the last one is done; emit waits on a full
// output register. Events causing no result skip the emit state and return to idle.
// Reset (synchronous, active low) empties the stack and sets the accent threshold to 100.
module mono_note_priority_stack import mnps_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mnps_in_if.sink          i_in,
    mnps_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [VEL_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [VEL_W-1:0]  r_thr;
    logic [ACT_W-1:0]  r_action;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;

    logic r_emit, r_cmd_p, r_leg_p, r_acc_p, r_use_top;
    logic w_emit, w_cmd_p, w_leg_p, w_acc_p, w_use_top;

    logic              r_out_valid, r_out_cmd, r_out_leg, r_out_acc;
    logic [NOTE_W-1:0] r_out_pitch;

    t_cell_ctl         w_ctl;
    logic              w_push_en;
    logic [CW-1:0]     w_push_pos;
    logic [NOTE_W-1:0] w_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_match, w_hit, w_occ, w_push;
    logic [IW-1:0]     w_top_idx;
    logic              w_found, w_full, w_was_top, w_load;

    assign w_top_idx = r_count[IW-1:0] - 1'b1;
    assign w_found   = w_hit[STACK_DEPTH-1];
    assign w_full    = (r_count == CW'(STACK_DEPTH));
    assign w_was_top = w_match[w_top_idx];
    assign w_load    = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [NOTE_W-1:0] w_up;
            logic              w_below;
            assign w_occ[gi]  = r_count > CW'(gi);
            assign w_push[gi] = w_push_en && (w_push_pos == CW'(gi));
            if (gi == STACK_DEPTH - 1) begin : g_top
                assign w_up = w_data[gi];
            end else begin : g_mid
                assign w_up = w_data[gi+1];
            end
            if (gi == 0) begin : g_bot
                assign w_below = 1'b0;
            end else begin : g_up
                assign w_below = w_hit[gi-1];
            end
            mnps_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[gi]),
                .i_push      (w_push[gi]),
                .i_up_data   (w_up),
                .i_hit_below (w_below),
                .o_data      (w_data[gi]),
                .o_match     (w_match[gi]),
                .o_hit       (w_hit[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: n_state = ST_UPDATE;
            ST_UPDATE: n_state = w_emit ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        w_ctl.search    = (r_state == ST_SEARCH);
        w_ctl.update    = 1'b0;
        w_ctl.shift_all = 1'b0;
        w_ctl.key       = r_note;
        w_push_en       = 1'b0;
        w_push_pos      = r_count;
        n_count         = r_count;
        w_emit          = 1'b0;
        w_cmd_p         = CMD_START;
        w_leg_p         = 1'b0;
        w_acc_p         = 1'b0;
        w_use_top       = 1'b0;
        if (r_state == ST_UPDATE) begin
            case (r_action)
                ACT_NOTE_ON: begin
                    w_ctl.update    = 1'b1;
                    w_ctl.shift_all = !w_found && w_full;
                    w_push_en       = 1'b1;
                    if (w_found || w_full) begin
                        w_push_pos = r_count - 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    w_emit  = 1'b1;
                    w_leg_p = (r_count != '0);
                    w_acc_p = (r_vel >= r_thr);
                end
                ACT_NOTE_OFF: begin
                    w_ctl.update = 1'b1;
                    if (w_found) begin
                        n_count = r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            w_emit  = 1'b1;
                            w_cmd_p = CMD_GATE_OFF;
                        end else if (w_was_top) begin
                            w_emit    = 1'b1;
                            w_leg_p   = 1'b1;
                            w_use_top = 1'b1;
                        end
                    end
                end
                ACT_ALL_OFF: begin
                    n_count = '0;
                    w_emit  = 1'b1;
                    w_cmd_p = CMD_GATE_OFF;
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_thr       <= ACCENT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) r_thr <= i_cfg_data;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_note   <= i_in.note;
            r_vel    <= i_in.velocity;
        end
        if (r_state == ST_UPDATE) begin
            r_emit    <= w_emit;
            r_cmd_p   <= w_cmd_p;
            r_leg_p   <= w_leg_p;
            r_acc_p   <= w_acc_p;
            r_use_top <= w_use_top;
        end
        if (w_load) begin
            r_out_cmd   <= r_cmd_p;
            r_out_leg   <= r_leg_p;
            r_out_acc   <= r_acc_p;
            if (r_cmd_p == CMD_GATE_OFF) begin
                r_out_pitch <= '0;
            end else if (r_use_top) begin
                r_out_pitch <= w_data[w_top_idx];
            end else begin
                r_out_pitch <= r_note;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.command    = r_out_cmd;
    assign o_out.pitch_note = r_out_pitch;
    assign o_out.legato     = r_out_leg;
    assign o_out.accent     = r_out_acc;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("held count beyond stack depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $onehot0(w_match))
        else $error("note held in more than one slot");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == ST_EMIT && r_emit))
        else $error("result beat not from emit state");

    a_gate_off_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.command == CMD_GATE_OFF) |->
        (o_out.pitch_note == '0 && !o_out.legato && !o_out.accent))
        else $error("gate-off beat with nonzero fields");

endmodule

### src/mnps_cell.sv
// One stack slot: holds a note, compares it with the key, shifts down from its upper neighbor.
// Depends on mnps_pkg.
module mnps_cell import mnps_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_occ,
    input  logic              i_push,
    input  logic [NOTE_W-1:0] i_up_data,
    input  logic              i_hit_below,
    output logic [NOTE_W-1:0] o_data,
    output logic              o_match,
    output logic              o_hit
);

    logic [NOTE_W-1:0] r_data;
    logic              r_match;

    assign o_data  = r_data;
    assign o_match = r_match;
    // set from the matching slot upward
    assign o_hit   = r_match | i_hit_below;

    always_ff @(posedge i_clk) begin
        if (i_ctl.search) begin
            r_match <= i_occ && (r_data == i_ctl.key);
        end
        if (i_ctl.update) begin
            if (i_push) begin
                r_data <= i_ctl.key;
            end else if (i_ctl.shift_all || o_hit) begin
                r_data <= i_up_data;
            end
        end
    end

endmodule

### verif/tb_top.sv
// Self-checking testbench for mono_note_priority_stack: queued note events, random gaps
// and stalls, a held-note predictor, and an in-order check of every voice command.
// Depends on mnps_pkg, mnps_if.sv and the RTL under src.
module tb_top;
    import mnps_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int GAP_PCT      = 32;
    localparam int SETTLE_CYC   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_EVENTS = 175;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } note_event_t;

    typedef struct packed {
        logic              command;
        logic [NOTE_W-1:0] pitch_note;
        logic              legato;
        logic              accent;
    } voice_cmd_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [VEL_W-1:0] i_cfg_data;

    mnps_in_if  ev_ch ();
    mnps_out_if cmd_ch ();

    mono_note_priority_stack u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_ch),
        .o_out      (cmd_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    note_event_t event_queue[$];
    voice_cmd_t  cmd_expected[$];
    int          mismatch_count;
    int          cycle_count;
    bit          beat_taken;
    bit          no_gaps;

    logic [NOTE_W-1:0] held_notes_model[STACK_DEPTH_D];
    int                held_model_count;
    logic [VEL_W-1:0]  accent_level;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ---------------- predictor ----------------
    function automatic int find_held(logic [NOTE_W-1:0] n);
        for (int i = 0; i < held_model_count; i++) begin
            if (held_notes_model[i] == n) return i;
        end
        return held_model_count;
    endfunction

    function automatic void drop_held(int pos);
        for (int i = pos; i < held_model_count - 1; i++) begin
            held_notes_model[i] = held_notes_model[i + 1];
        end
        held_model_count--;
    endfunction

    function automatic bit apply_note_event(note_event_t ev, output voice_cmd_t cmd);
        int pos;
        bit was_held;
        bit was_top;
        cmd = '0;
        case (ev.action)
            ACT_NOTE_ON: begin
                was_held = held_model_count > 0;
                pos = find_held(ev.note);
                if (pos < held_model_count) drop_held(pos);
                if (held_model_count >= STACK_DEPTH_D) drop_held(0);
                held_notes_model[held_model_count] = ev.note;
                held_model_count++;
                cmd.command    = CMD_START;
                cmd.pitch_note = ev.note;
                cmd.legato     = was_held;
                cmd.accent     = ev.velocity >= accent_level;
                return 1'b1;
            end
            ACT_NOTE_OFF: begin
                pos = find_held(ev.note);
                if (pos >= held_model_count) return 1'b0;
                was_top = pos == held_model_count - 1;
                drop_held(pos);
                if (held_model_count == 0) begin
                    cmd.command = CMD_GATE_OFF;
                    return 1'b1;
                end
                if (was_top) begin
                    cmd.command    = CMD_START;
                    cmd.pitch_note = held_notes_model[held_model_count - 1];
                    cmd.legato     = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            ACT_ALL_OFF: begin
                held_model_count = 0;
                cmd.command = CMD_GATE_OFF;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        voice_cmd_t cmd;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && ev_ch.valid && ev_ch.ready) begin
            beat_taken = 1'b1;
            if (apply_note_event(event_queue[0], cmd)) cmd_expected.push_back(cmd);
            void'(event_queue.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ev_ch.valid <= 1'b0;
        end else if (!(ev_ch.valid && !beat_taken)) begin
            if (event_queue.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                ev_ch.valid    <= 1'b1;
                ev_ch.action   <= event_queue[0].action;
                ev_ch.note     <= event_queue[0].note;
                ev_ch.velocity <= event_queue[0].velocity;
            end else begin
                ev_ch.valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // ---------------- monitor ----------------
    always @(negedge i_clk) begin
        cmd_ch.ready <= no_gaps || $urandom_range(99) >= GAP_PCT;
    end

    always @(posedge i_clk) begin
        voice_cmd_t want;
        voice_cmd_t got;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            got = {cmd_ch.command, cmd_ch.pitch_note, cmd_ch.legato, cmd_ch.accent};
            if (cmd_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected beat: cmd=%0d pitch=%0d legato=%0d accent=%0d",
                         $time, got.command, got.pitch_note, got.legato, got.accent);
            end else begin
                want = cmd_expected.pop_front();
                if (got.command !== want.command) begin
                    mismatch_count++;
                    $display("%0t command: exp %0d got %0d", $time, want.command, got.command);
                end
                if (got.pitch_note !== want.pitch_note) begin
                    mismatch_count++;
                    $display("%0t pitch_note: exp %0d got %0d", $time,
                             want.pitch_note, got.pitch_note);
                end
                if (got.legato !== want.legato) begin
                    mismatch_count++;
                    $display("%0t legato: exp %0d got %0d", $time, want.legato, got.legato);
                end
                if (got.accent !== want.accent) begin
                    mismatch_count++;
                    $display("%0t accent: exp %0d got %0d", $time, want.accent, got.accent);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_event(logic [ACT_W-1:0] act, logic [NOTE_W-1:0] n,
                               logic [VEL_W-1:0] vel);
        note_event_t ev;
        ev.action   = act;
        ev.note     = n;
        ev.velocity = vel;
        event_queue.push_back(ev);
    endtask

    task automatic queue_random_events(int count);
        int made;
        int roll;
        int run_len;
        logic [NOTE_W-1:0] pool_base;
        logic [NOTE_W-1:0] n;
        made = 0;
        pool_base = NOTE_W'($urandom_range(127));
        while (made < count) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                // overflow run: distinct note-ons, from the stack depth to three past it
                run_len = $urandom_range(STACK_DEPTH_D + 3, STACK_DEPTH_D);
                n = NOTE_W'($urandom_range(127));
                for (int i = 0; i < run_len; i++) begin
                    queue_event(ACT_NOTE_ON, n + i[NOTE_W-1:0], VEL_W'($urandom_range(127)));
                end
                made += run_len;
            end else begin
                if ($urandom_range(99) < 80) n = NOTE_W'(pool_base + $urandom_range(11));
                else n = NOTE_W'($urandom_range(127));
                if (roll < 55) queue_event(ACT_NOTE_ON, n, VEL_W'($urandom_range(127)));
                else if (roll < 91) queue_event(ACT_NOTE_OFF, n, VEL_W'($urandom_range(127)));
                else if (roll < 96) queue_event(ACT_ALL_OFF, n, VEL_W'($urandom_range(127)));
                else queue_event(ACT_UNUSED, n, VEL_W'($urandom_range(127)));
                made++;
            end
        end
    endtask

    task automatic drain_and_settle();
        while (event_queue.size() != 0 || cmd_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [VEL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        accent_level = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        ev_ch.valid      = 1'b0;
        ev_ch.action     = '0;
        ev_ch.note       = '0;
        ev_ch.velocity   = '0;
        cmd_ch.ready     = 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        beat_taken       = 1'b0;
        no_gaps          = 1'b0;
        held_model_count = 0;
        accent_level     = ACCENT_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: threshold at its reset value
        queue_event(ACT_ALL_OFF, 7'd0, 7'd0);
        queue_event(ACT_UNUSED, 7'd0, 7'd0);
        queue_event(ACT_NOTE_OFF, 7'd5, 7'd0);
        queue_event(ACT_NOTE_ON, 7'd0, 7'd127);
        queue_event(ACT_NOTE_ON, 7'd127, 7'd0);
        queue_event(ACT_NOTE_ON, 7'd64, 7'd100);
        queue_event(ACT_NOTE_ON, 7'd65, 7'd99);
        queue_event(ACT_NOTE_ON, 7'd0, 7'd50);
        queue_event(ACT_NOTE_OFF, 7'd127, 7'd127);
        queue_event(ACT_NOTE_OFF, 7'd0, 7'd0);
        for (int i = 0; i < 6; i++) begin
            queue_event(ACT_NOTE_ON, NOTE_W'(10 + i), VEL_W'($urandom_range(127)));
        end
        queue_event(ACT_NOTE_ON, 7'd16, 7'd127);
        queue_event(ACT_NOTE_OFF, 7'd64, 7'd0);
        queue_event(ACT_NOTE_OFF, 7'd16, 7'd0);
        queue_event(ACT_ALL_OFF, 7'd127, 7'd127);
        queue_event(ACT_NOTE_ON, 7'd33, 7'd1);
        queue_event(ACT_NOTE_OFF, 7'd33, 7'd127);
        queue_event(ACT_UNUSED, 7'd127, 7'd127);
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_threshold(7'd0);
        no_gaps = 1'b1;
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();
        no_gaps = 1'b0;

        write_threshold(7'd127);
        queue_event(ACT_NOTE_ON, 7'd40, 7'd126);
        queue_event(ACT_NOTE_ON, 7'd41, 7'd127);
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_threshold(VEL_W'($urandom_range(127)));
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_threshold(7'd1);
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_threshold(VEL_W'($urandom_range(127)));
        queue_random_events(PHASE_EVENTS);
        drain_and_settle();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
src/mnps_pkg.sv
src/mnps_if.sv
src/mnps_cell.sv
src/mono_note_priority_stack.sv
verif/tb_top.sv
